// ===== src/handshake_ack_receiver_unit_macros.svh =====
// assertion macros for the handshake ack receiver
`ifndef HANDSHAKE_ACK_RECEIVER_UNIT_MACROS_SVH
`define HANDSHAKE_ACK_RECEIVER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during rst
`define HAR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define HAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define HAR_ASSERT_NOW(lbl, ante, cons)
`define HAR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== src/hsk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsk_pkg;

  // packet flag bits
  localparam logic [7:0] FL_SYN    = 8'h01;
  localparam logic [7:0] FL_ACK    = 8'h02;
  localparam logic [7:0] FL_FIN    = 8'h04;
  localparam logic [7:0] FL_DATA   = 8'h08;
  localparam logic [7:0] FL_SYNACK = FL_SYN | FL_ACK;

  // error counter ceiling
  localparam logic [15:0] ERR_MAX = 16'hFFFF;

  // command queue between front and back, depth a power of two
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    PH_LISTEN = 2'd0,
    PH_WAIT   = 2'd1,
    PH_OPEN   = 2'd2,
    PH_CLOSED = 2'd3
  } phase_t;

  // classified packet handed from front to back
  typedef struct packed {
    logic       bad;
    logic       syn;
    logic       ack_one;
    logic       fin;
    logic       data_one;
    logic [7:0] seq;
    logic [7:0] seq_inc;
    logic [7:0] data;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic        reply_valid;
    logic [7:0]  reply_ack_num;
    logic [7:0]  reply_flags;
    logic [15:0] reply_checksum;
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic        checksum_bad;
    phase_t      link_phase;
    logic [6:0]  chars_taken;
    logic [15:0] bad_count;
  } res_t;

  // inverted 16-bit sum; a sum of a few bytes never carries out of 16 bits
  function automatic logic [15:0] inv_sum(input logic [10:0] sum);
    return ~{5'd0, sum};
  endfunction

endpackage

`default_nettype wire

// ===== src/hsk_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsk_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_seq,
  input  wire logic [7:0]  rx_ack_num,
  input  wire logic [7:0]  rx_flags,
  input  wire logic [7:0]  rx_len,
  input  wire logic [7:0]  rx_data,
  input  wire logic [15:0] rx_checksum,
  output logic             cmd_valid,
  output hsk_pkg::cmd_t    cmd,
  input  wire logic        cmd_ready
);
  import hsk_pkg::*;

  logic [10:0] sum;
  cmd_t        cls;

  // checksum check and flag decode
  always_comb begin
    sum = 11'(rx_seq) + 11'(rx_ack_num) + 11'(rx_flags) + 11'(rx_len) + 11'(rx_data);
    cls.bad      = (inv_sum(sum) != rx_checksum);
    cls.syn      = ((rx_flags & FL_SYN) != 8'd0);
    cls.ack_one  = ((rx_flags & FL_ACK) != 8'd0) && (rx_ack_num == 8'd1);
    cls.fin      = ((rx_flags & FL_FIN) != 8'd0);
    cls.data_one = ((rx_flags & FL_DATA) != 8'd0) && (rx_len == 8'd1);
    cls.seq      = rx_seq;
    cls.seq_inc  = rx_seq + 8'd1;
    cls.data     = rx_data;
  end

  assign in_ready = !cmd_valid || cmd_ready;

  // classify stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  // classify stage payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== src/hsk_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsk_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire hsk_pkg::cmd_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output hsk_pkg::cmd_t      pop_data
);
  import hsk_pkg::*;

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;
  logic           pop;

  assign push_ready = (count != (QAW+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/hsk_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsk_back #(
  parameter int MSG_CAP = 99
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire hsk_pkg::cmd_t cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hsk_pkg::res_t      res
);
  import hsk_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  exp_seq;
  logic [7:0]  exp_seq_next;
  logic [6:0]  char_total;
  logic [6:0]  char_total_next;
  logic [15:0] err_total;
  logic [15:0] err_total_next;
  res_t        res_next;
  logic        take;

  assign cmd_ready = !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;

  // link state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LISTEN;
      exp_seq    <= 8'd1;
      char_total <= '0;
      err_total  <= '0;
    end else if (take) begin
      phase      <= phase_next;
      exp_seq    <= exp_seq_next;
      char_total <= char_total_next;
      err_total  <= err_total_next;
    end
  end

  // next state and result word
  always_comb begin
    phase_next      = phase;
    exp_seq_next    = exp_seq;
    char_total_next = char_total;
    err_total_next  = err_total;
    res_next        = '0;

    if (phase != PH_CLOSED) begin
      res_next.checksum_bad = cmd.bad;
      if (cmd.bad) begin
        if (err_total != ERR_MAX) begin
          err_total_next = err_total + 16'd1;
        end
        if (phase == PH_WAIT) begin
          phase_next = PH_LISTEN;
        end
      end else begin
        unique case (phase)
          PH_LISTEN: begin
            if (cmd.syn) begin
              res_next.reply_valid   = 1'b1;
              res_next.reply_ack_num = cmd.seq_inc;
              res_next.reply_flags   = FL_SYNACK;
              phase_next             = PH_WAIT;
            end
          end
          PH_WAIT: begin
            phase_next = cmd.ack_one ? PH_OPEN : PH_LISTEN;
          end
          PH_OPEN: begin
            if (cmd.fin) begin
              res_next.reply_valid   = 1'b1;
              res_next.reply_ack_num = cmd.seq_inc;
              res_next.reply_flags   = FL_ACK;
              phase_next             = PH_CLOSED;
            end else if (cmd.data_one) begin
              // in-order byte: store while room, always advance
              if (cmd.seq == exp_seq) begin
                if (char_total < 7'(MSG_CAP)) begin
                  char_total_next     = char_total + 7'd1;
                  res_next.byte_valid = 1'b1;
                  res_next.byte_value = cmd.data;
                end
                exp_seq_next = exp_seq + 8'd1;
              end
              // cumulative or duplicate ack
              res_next.reply_valid   = 1'b1;
              res_next.reply_ack_num = exp_seq_next;
              res_next.reply_flags   = FL_ACK;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (res_next.reply_valid) begin
      res_next.reply_checksum =
        inv_sum(11'(res_next.reply_ack_num) + 11'(res_next.reply_flags));
    end
    res_next.link_phase  = phase_next;
    res_next.chars_taken = char_total_next;
    res_next.bad_count   = err_total_next;
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/handshake_ack_receiver_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake             payload
// in        in_valid / in_ready   rx_seq rx_ack_num rx_flags rx_len rx_data rx_checksum
// out       out_valid / out_ready reply_* byte_* checksum_bad link_phase chars_taken bad_count
//
// one packet per cycle sustained while out is not stalled; each packet yields exactly one result word
// path: classify register, queue slot, link state update into the output register
// rst (synchronous) returns the link to listen, expected sequence 1, counters 0
// a two-word command queue lets the classify stage keep taking packets while out is stalled
// in_ready drops only once the queue and the classify register are both full

module handshake_ack_receiver_unit #(
  parameter int MSG_CAP = 99
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_seq,
  input  wire logic [7:0]  rx_ack_num,
  input  wire logic [7:0]  rx_flags,
  input  wire logic [7:0]  rx_len,
  input  wire logic [7:0]  rx_data,
  input  wire logic [15:0] rx_checksum,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             reply_valid,
  output logic [7:0]       reply_ack_num,
  output logic [7:0]       reply_flags,
  output logic [15:0]      reply_checksum,
  output logic             byte_valid,
  output logic [7:0]       byte_value,
  output logic             checksum_bad,
  output logic [1:0]       link_phase,
  output logic [6:0]       chars_taken,
  output logic [15:0]      bad_count
);
  import hsk_pkg::*;

`include "handshake_ack_receiver_unit_macros.svh"

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;
  res_t res;

  // accept and classify
  hsk_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_seq      (rx_seq),
    .rx_ack_num  (rx_ack_num),
    .rx_flags    (rx_flags),
    .rx_len      (rx_len),
    .rx_data     (rx_data),
    .rx_checksum (rx_checksum),
    .cmd_valid   (f_valid),
    .cmd         (f_cmd),
    .cmd_ready   (f_ready)
  );

  // command queue
  hsk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  // link state and result
  hsk_back #(
    .MSG_CAP (MSG_CAP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // result fields
  assign reply_valid    = res.reply_valid;
  assign reply_ack_num  = res.reply_ack_num;
  assign reply_flags    = res.reply_flags;
  assign reply_checksum = res.reply_checksum;
  assign byte_valid     = res.byte_valid;
  assign byte_value     = res.byte_value;
  assign checksum_bad   = res.checksum_bad;
  assign link_phase     = res.link_phase;
  assign chars_taken    = res.chars_taken;
  assign bad_count      = res.bad_count;

  // a stored byte is always acknowledged on an open link
  `HAR_ASSERT_NOW(a_byte_acked, out_valid && byte_valid, reply_valid && (link_phase == PH_OPEN))
  // a failed packet produces neither reply nor byte
  `HAR_ASSERT_NOW(a_bad_silent, out_valid && checksum_bad, !reply_valid && !byte_valid)
  // a syn-ack moves the link to awaiting the final ack
  `HAR_ASSERT_NOW(a_synack_wait, out_valid && reply_valid && (reply_flags == FL_SYNACK),
                  link_phase == PH_WAIT)
  // a word leaving the classify stage is taken by the queue when it has room
  `HAR_ASSERT_NEXT(a_queue_take, f_valid && f_ready && !(in_valid && in_ready), !f_valid)

endmodule

`default_nettype wire
